// ===== hw/rtl/sis_pkg.sv =====
// ----------------------------------------------------------------------------
// sis_pkg
// Shared constants, codes and types of the sorted ID set register.
// ----------------------------------------------------------------------------
`default_nettype none

package sis_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned ID_W     = 31;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STAT_W   = 3;

  localparam logic [ID_W-1:0] MAX_ID_RST = ID_W'(1234567890);

  typedef enum logic [OP_W-1:0] {
    OP_REGISTER   = 2'd0,
    OP_UNREGISTER = 2'd1,
    OP_QUERY      = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_PRESENT = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_SHIFT,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] id;
  } sis_req_t;

  typedef struct packed {
    status_e          status;
    logic             is_member;
    logic [CNT_W-1:0] entry_count;
    logic [ID_W-1:0]  lowest_id;
  } sis_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sis_engine.sv =====
// ----------------------------------------------------------------------------
// sis_engine
// Ordered ID store: linear search, then shift up or down through one memory.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_engine (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire logic [sis_pkg::ID_W-1:0]   max_id_i,
  input  wire                             req_valid_i,
  output logic                            req_ready_o,
  input  wire sis_pkg::sis_req_t          req_i,
  output logic                            res_valid_o,
  input  wire                             res_ready_i,
  output sis_pkg::sis_res_t               res_o
);
  import sis_pkg::*;

  // storage: one write port, one registered read port
  logic [ID_W-1:0]   mem_q [CAPACITY];
  logic [ID_W-1:0]   rdata_q;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ID_W-1:0]   mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  state_e            state_q, state_d;
  logic [OP_W-1:0]   op_q, op_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [CNT_W-1:0]  scan_q, scan_d;
  logic              rvld_q, rvld_d;
  logic [ADDR_W-1:0] ridx_q, ridx_d;
  logic [CNT_W-1:0]  pos_q, pos_d;
  logic              present_q, present_d;
  status_e           status_q, status_d;
  logic              ins_q, ins_d;
  logic              del_q, del_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [ADDR_W-1:0] sh_q, sh_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ID_W-1:0]   low_q, low_d;

  logic hit, scan_end, id_ok, fin_go;
  logic [CNT_W-1:0] cnt_new;

  // key is negative: every entry lies above it
  assign hit      = rvld_q && (key_q[KEY_W-1] || (rdata_q >= key_q[ID_W-1:0]));
  assign scan_end = (scan_q == cnt_q);
  assign id_ok    = !key_q[KEY_W-1] && (key_q[ID_W-1:0] != '0)
                    && (key_q[ID_W-1:0] <= max_id_i);
  assign fin_go   = (state_q == S_FINISH) && res_ready_i;
  assign cnt_new  = ins_q ? cnt_q + CNT_W'(1) : (del_q ? cnt_q - CNT_W'(1) : cnt_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (hit || scan_end) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_SHIFT;
      end
      S_SHIFT: begin
        if ((rem_q == '0) && !rvld_q) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs: memory port control, handshakes, result
  always_comb begin
    mem_re      = 1'b0;
    mem_raddr   = '0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = rdata_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
      end
      S_SEARCH: begin
        if (!hit && !scan_end) begin
          mem_re    = 1'b1;
          mem_raddr = scan_q[ADDR_W-1:0];
        end
      end
      S_SHIFT: begin
        if (rvld_q) begin
          mem_we    = 1'b1;
          mem_waddr = ins_q ? ridx_q + ADDR_W'(1) : ridx_q - ADDR_W'(1);
        end
        if (rem_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = sh_q;
        end
      end
      S_FINISH: begin
        res_valid_o = 1'b1;
        if (res_ready_i && ins_q) begin
          mem_we    = 1'b1;
          mem_waddr = pos_q[ADDR_W-1:0];
          mem_wdata = key_q[ID_W-1:0];
        end
      end
      default: ;
    endcase
    res_o.status      = status_q;
    res_o.is_member   = ins_q ? 1'b1 : (del_q ? 1'b0 : present_q);
    res_o.entry_count = cnt_new;
    res_o.lowest_id   = (cnt_new == '0) ? '0
                      : ((ins_q && (pos_q == '0)) ? key_q[ID_W-1:0] : low_q);
  end

  // datapath
  always_comb begin
    op_d      = op_q;
    key_d     = key_q;
    scan_d    = scan_q;
    rvld_d    = 1'b0;
    ridx_d    = ridx_q;
    pos_d     = pos_q;
    present_d = present_q;
    status_d  = status_q;
    ins_d     = ins_q;
    del_d     = del_q;
    rem_d     = rem_q;
    sh_d      = sh_q;
    cnt_d     = cnt_q;
    // shadow copy of slot 0
    low_d     = (mem_we && (mem_waddr == '0)) ? mem_wdata : low_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          op_d   = req_i.op;
          key_d  = req_i.id;
          scan_d = '0;
          ins_d  = 1'b0;
          del_d  = 1'b0;
        end
      end
      S_SEARCH: begin
        if (hit) begin
          pos_d     = {1'b0, ridx_q};
          present_d = !key_q[KEY_W-1] && (rdata_q == key_q[ID_W-1:0]);
        end else if (scan_end) begin
          pos_d     = cnt_q;
          present_d = 1'b0;
        end else begin
          rvld_d = 1'b1;
          ridx_d = scan_q[ADDR_W-1:0];
          scan_d = scan_q + CNT_W'(1);
        end
      end
      S_DECIDE: begin
        status_d = ST_OK;
        rem_d    = '0;
        case (op_q)
          OP_REGISTER: begin
            if (!id_ok) begin
              status_d = ST_INVALID;
            end else if (present_q) begin
              status_d = ST_PRESENT;
            end else if (cnt_q == CNT_W'(CAPACITY)) begin
              status_d = ST_FULL;
            end else begin
              ins_d = 1'b1;
              rem_d = cnt_q - pos_q;
              sh_d  = ADDR_W'(cnt_q - CNT_W'(1));
            end
          end
          OP_UNREGISTER: begin
            if (!present_q) begin
              status_d = ST_ABSENT;
            end else begin
              del_d = 1'b1;
              rem_d = cnt_q - pos_q - CNT_W'(1);
              sh_d  = ADDR_W'(pos_q + CNT_W'(1));
            end
          end
          default: ;
        endcase
      end
      S_SHIFT: begin
        if (rem_q != '0) begin
          rvld_d = 1'b1;
          ridx_d = sh_q;
          sh_d   = ins_q ? sh_q - ADDR_W'(1) : sh_q + ADDR_W'(1);
          rem_d  = rem_q - CNT_W'(1);
        end
      end
      S_FINISH: begin
        if (res_ready_i) begin
          cnt_d = cnt_new;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rvld_q  <= 1'b0;
      cnt_q   <= '0;
      ins_q   <= 1'b0;
      del_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rvld_q  <= rvld_d;
      cnt_q   <= cnt_d;
      ins_q   <= ins_d;
      del_q   <= del_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    scan_q    <= scan_d;
    ridx_q    <= ridx_d;
    pos_q     <= pos_d;
    present_q <= present_d;
    status_q  <= status_d;
    rem_q     <= rem_d;
    sh_q      <= sh_d;
    low_q     <= low_d;
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("stored count beyond capacity");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE) |-> (pos_q <= cnt_q))
    else $error("search position beyond stored count");

  a_shift_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT && mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("shift reads and writes the same slot");

  a_one_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ins_q && del_q))
    else $error("insert and delete both pending");

  a_cnt_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_go && ins_q) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("insert did not grow the count");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_id_set_register.sv =====
// ----------------------------------------------------------------------------
// sorted_id_set_register
// Bounded set of IDs kept in ascending order, with register/unregister/query.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one request per beat. tuser = opcode (0 register, 1 unregister,
//     2 query; 3 acts as query), tdata = student_id, 32-bit two's complement.
//   m_axis: one result per request. tuser = status (0 ok, 1 invalid id,
//     2 already present, 3 not present, 4 store full); tdata = is_member,
//     entry_count, lowest_id (0 when the set is empty).
//   cfg: cfg_data_i writes max_id; only while no request is in flight.
// Timing: one request at a time. A linear search walks the memory from
//   slot 0 to the first entry not below the ID, then an ordered insert or
//   delete shifts the slots above it one per cycle through the single
//   memory port pair.
// Reset: the set is empty and max_id is 1234567890; the memory contents
//   are not cleared, since the count bounds every read.
// Stall: the result sits in an output register; the next request is taken
//   while it waits, and that one holds in its last step until the output
//   register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_id_set_register (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // request stream
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [31:0]                 s_axis_tdata,  // [31:0] student_id
  input  wire logic [sis_pkg::OP_W-1:0]    s_axis_tuser,  // [1:0] opcode
  // result stream
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // [0] is_member, [11:1] entry_count, [42:12] lowest_id, [47:43] zero
  output logic [47:0]                      m_axis_tdata,
  output logic [sis_pkg::STAT_W-1:0]       m_axis_tuser,  // [2:0] status
  // max_id write
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [sis_pkg::ID_W-1:0]    cfg_data_i
);
  import sis_pkg::*;

  logic [ID_W-1:0] max_id_q;
  sis_req_t        req;
  logic            res_valid;
  logic            res_ready;
  sis_res_t        res;
  logic            out_vld_q;
  sis_res_t        out_q;

  // config register is always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_id_q <= MAX_ID_RST;
    end else if (cfg_valid_i) begin
      max_id_q <= cfg_data_i;
    end
  end

  assign req.op = s_axis_tuser;
  assign req.id = s_axis_tdata;

  sis_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_id_i    (max_id_q),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register: free when empty or being drained this cycle
  assign res_ready = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {5'b0, out_q.lowest_id, out_q.entry_count, out_q.is_member};

endmodule

`default_nettype wire
